>>> hdl/sensor_average_health_score_macros.svh
// ----------------------------------------------------------------------------
// Sensor average health score: assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SENSOR_AVERAGE_HEALTH_SCORE_MACROS_SVH
`define SENSOR_AVERAGE_HEALTH_SCORE_MACROS_SVH
`ifndef SYNTH
`define SAHS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sahs: same-cycle check failed");
`define SAHS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sahs: next-cycle check failed");
`else
`define SAHS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SAHS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/sahs_pkg.sv
// ----------------------------------------------------------------------------
// sahs_pkg
// Shared types and constants of the sensor average health score block.
// ----------------------------------------------------------------------------
package sahs_pkg;

    localparam int M_W        = 12;
    localparam int L_W        = 16;
    localparam int PCT_W      = 7;
    localparam int CPP_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int MNUM_W     = 19;
    localparam int BAND_NUM_W = 14;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    localparam logic [CFG_IDX_W-1:0] CFG_DRY      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WET      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_M_LO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_M_HI     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_L_LO     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_L_HI     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CPP      = 3'd6;

    localparam logic [M_W-1:0]   RST_DRY  = 12'd3450;
    localparam logic [M_W-1:0]   RST_WET  = 12'd2200;
    localparam logic [PCT_W-1:0] RST_M_LO = 7'd60;
    localparam logic [PCT_W-1:0] RST_M_HI = 7'd80;
    localparam logic [PCT_W-1:0] RST_L_LO = 7'd40;
    localparam logic [PCT_W-1:0] RST_L_HI = 7'd60;
    localparam logic [CPP_W-1:0] RST_CPP  = 8'd12;

    typedef struct packed {
        logic [M_W-1:0] moisture_sample;
        logic [L_W-1:0] light_sample;
    } t_sahs_in;

    typedef struct packed {
        logic [PCT_W-1:0] moisture_pct;
        logic [PCT_W-1:0] light_pct;
        logic [PCT_W-1:0] health_score;
    } t_sahs_out;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> hdl/sensor_average_health_score.sv
// ----------------------------------------------------------------------------
// sensor_average_health_score
// Windowed moisture/light averager with band-based plant health score.
//
//   channel | handshake              | payload
//   in      | i_in_valid / o_in_stall | i_in_data  (moisture, light sample)
//   out     | o_out_valid / i_out_stall| o_out_data (moisture %, light %, score)
//   cfg     | i_cfg_we               | i_cfg_index, i_cfg_data
//
// Each request makes five passes through the shared two-bit-per-cycle divider.
// Window samples sit in one RAM: read at accept, written back the next cycle.
// Synchronous reset restores register defaults and empties the window.
// A stalled result waits in the output register; the next request is still
// taken and holds at its last step until the output frees.
// ----------------------------------------------------------------------------
`include "sensor_average_health_score_macros.svh"

module sensor_average_health_score #(
    parameter int WINDOW_DEPTH = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  sahs_pkg::t_sahs_in                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output sahs_pkg::t_sahs_out                  o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [sahs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sahs_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import sahs_pkg::*;

    localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int MT_W    = $clog2(WINDOW_DEPTH * 4095 + 1);
    localparam int LT_W    = $clog2(WINDOW_DEPTH * 65535 + 1);
    localparam int DIV_RAW = (LT_W > MNUM_W) ? LT_W : MNUM_W;
    localparam int DIV_W   = DIV_RAW + (DIV_RAW % 2);
    localparam int DEN_RAW = $clog2(WINDOW_DEPTH * 255 + 1);
    localparam int VW      = (DEN_RAW > M_W) ? DEN_RAW : M_W;
    localparam int RAM_W   = M_W + L_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD, ST_MAVG, ST_MPCT, ST_LPCT, ST_MSCORE, ST_LSCORE, ST_FIN
    } t_state;

    typedef struct packed {
        logic                  in_band;
        logic                  below;
        logic [BAND_NUM_W-1:0] num;
        logic [PCT_W-1:0]      den;
    } t_band_op;

    function automatic t_band_op band_op(input logic [PCT_W-1:0] pct,
                                         input logic [PCT_W-1:0] lo,
                                         input logic [PCT_W-1:0] hi);
        t_band_op b;
        b.in_band = (pct >= lo) && (pct <= hi);
        b.below   = (pct < lo);
        if (b.below) begin
            b.num = BAND_NUM_W'(pct) * BAND_NUM_W'(PCT_MAX);
            b.den = lo;
        end else begin
            b.num = BAND_NUM_W'(pct - hi) * BAND_NUM_W'(PCT_MAX);
            b.den = PCT_MAX - hi;
        end
        return b;
    endfunction

    // configuration
    logic [M_W-1:0]   r_dry, r_wet;
    logic [PCT_W-1:0] r_m_lo, r_m_hi, r_l_lo, r_l_hi;
    logic [CPP_W-1:0] r_cpp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dry  <= RST_DRY;
            r_wet  <= RST_WET;
            r_m_lo <= RST_M_LO;
            r_m_hi <= RST_M_HI;
            r_l_lo <= RST_L_LO;
            r_l_hi <= RST_L_HI;
            r_cpp  <= RST_CPP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DRY:  r_dry  <= i_cfg_data[M_W-1:0];
                CFG_WET:  r_wet  <= i_cfg_data[M_W-1:0];
                CFG_M_LO: r_m_lo <= i_cfg_data[PCT_W-1:0];
                CFG_M_HI: r_m_hi <= i_cfg_data[PCT_W-1:0];
                CFG_L_LO: r_l_lo <= i_cfg_data[PCT_W-1:0];
                CFG_L_HI: r_l_hi <= i_cfg_data[PCT_W-1:0];
                CFG_CPP:  r_cpp  <= i_cfg_data[CPP_W-1:0];
                default: ;
            endcase
        end
    end

    t_state            r_state, n_state;
    t_sahs_in          r_in, n_in;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_full, n_full;
    logic [MT_W-1:0]   r_mtot, n_mtot;
    logic [LT_W-1:0]   r_ltot, n_ltot;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [M_W-1:0]    r_mavg, n_mavg;
    logic [PCT_W-1:0]  r_mpct, n_mpct;
    logic [PCT_W-1:0]  r_lpct, n_lpct;
    logic [PCT_W-1:0]  r_mscore, n_mscore;
    logic [PCT_W-1:0]  r_lscore, n_lscore;
    logic              r_div_run, n_div_run;
    logic              r_out_valid, n_out_valid;
    t_sahs_out         r_out, n_out;

    logic              in_acc;
    logic [RAM_W-1:0]  ram_rdata;
    logic              ram_we;
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [VW-1:0]     div_divisor;
    t_div_stat         div_stat;
    logic [DIV_W-1:0]  div_quo;

    logic [M_W:0]      m_diff, m_run, m_diff_abs, m_run_abs;
    logic              m_neg, m_run_zero;
    logic [CPP_W-1:0]  cpp_eff;
    t_band_op          m_band, l_band;
    logic [PCT_W-1:0]  q_pct;

    logic              out_in_range;
    logic              count_in_range;
    logic              idle_no_req;

    assign in_acc = i_in_valid && !o_in_stall;
    assign ram_we = (r_state == ST_RD);

    sahs_ram #(
        .WIDTH (RAM_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata ({r_in.moisture_sample, r_in.light_sample}),
        .i_re    (in_acc),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    sahs_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    assign m_diff     = {1'b0, r_mavg} - {1'b0, r_dry};
    assign m_run      = {1'b0, r_wet} - {1'b0, r_dry};
    assign m_diff_abs = m_diff[M_W] ? (~m_diff + 1'b1) : m_diff;
    assign m_run_abs  = m_run[M_W] ? (~m_run + 1'b1) : m_run;
    assign m_neg      = m_diff[M_W] ^ m_run[M_W];
    assign m_run_zero = (m_run == '0);
    assign cpp_eff    = (r_cpp == '0) ? CPP_W'(1) : r_cpp;
    assign m_band     = band_op(r_mpct, r_m_lo, r_m_hi);
    assign l_band     = band_op(r_lpct, r_l_lo, r_l_hi);
    assign q_pct      = (div_quo > DIV_W'(PCT_MAX)) ? PCT_MAX : div_quo[PCT_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_slot      = r_slot;
        n_full      = r_full;
        n_mtot      = r_mtot;
        n_ltot      = r_ltot;
        n_count     = r_count;
        n_mavg      = r_mavg;
        n_mpct      = r_mpct;
        n_lpct      = r_lpct;
        n_mscore    = r_mscore;
        n_lscore    = r_lscore;
        n_div_run   = r_div_run;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_in    = i_in_data;
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_mtot = r_mtot - (r_full ? MT_W'(ram_rdata[RAM_W-1:L_W]) : '0)
                         + MT_W'(r_in.moisture_sample);
                n_ltot = r_ltot - (r_full ? LT_W'(ram_rdata[L_W-1:0]) : '0)
                         + LT_W'(r_in.light_sample);
                if (r_slot == SLOT_W'(WINDOW_DEPTH - 1)) begin
                    n_slot = '0;
                    n_full = 1'b1;
                end else begin
                    n_slot = r_slot + SLOT_W'(1);
                end
                n_count = n_full ? CNT_W'(WINDOW_DEPTH) : (CNT_W'(r_slot) + CNT_W'(1));
                n_state = ST_MAVG;
            end
            ST_MAVG: begin
                div_dividend = DIV_W'(r_mtot);
                div_divisor  = VW'(r_count);
                if (div_stat.done) begin
                    n_mavg  = div_quo[M_W-1:0];
                    n_state = ST_MPCT;
                end
            end
            ST_MPCT: begin
                div_dividend = DIV_W'(MNUM_W'(m_diff_abs[M_W-1:0]) * MNUM_W'(PCT_MAX));
                div_divisor  = VW'(m_run_abs[M_W-1:0]);
                if (div_stat.done) begin
                    n_mpct  = (m_run_zero || m_neg) ? '0 : q_pct;
                    n_state = ST_LPCT;
                end
            end
            ST_LPCT: begin
                div_dividend = DIV_W'(r_ltot);
                div_divisor  = VW'(r_count) * VW'(cpp_eff);
                if (div_stat.done) begin
                    n_lpct  = q_pct;
                    n_state = ST_MSCORE;
                end
            end
            ST_MSCORE: begin
                div_dividend = DIV_W'(m_band.num);
                div_divisor  = VW'(m_band.den);
                if (div_stat.done) begin
                    n_mscore = m_band.in_band ? PCT_MAX :
                               m_band.below   ? div_quo[PCT_W-1:0] :
                                                PCT_MAX - div_quo[PCT_W-1:0];
                    n_state  = ST_LSCORE;
                end
            end
            ST_LSCORE: begin
                div_dividend = DIV_W'(l_band.num);
                div_divisor  = VW'(l_band.den);
                if (div_stat.done) begin
                    n_lscore = l_band.in_band ? PCT_MAX :
                               l_band.below   ? div_quo[PCT_W-1:0] :
                                                PCT_MAX - div_quo[PCT_W-1:0];
                    n_state  = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.moisture_pct = r_mpct;
                    n_out.light_pct    = r_lpct;
                    n_out.health_score =
                        PCT_W'(((PCT_W + 1)'(r_mscore) + (PCT_W + 1)'(r_lscore)) >> 1);
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if ((r_state inside {ST_MAVG, ST_MPCT, ST_LPCT, ST_MSCORE, ST_LSCORE})
                && !r_div_run) begin
            div_start = 1'b1;
            n_div_run = 1'b1;
        end
        if (div_stat.done) begin
            n_div_run = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= '0;
            r_full      <= 1'b0;
            r_mtot      <= '0;
            r_ltot      <= '0;
            r_div_run   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_full      <= n_full;
            r_mtot      <= n_mtot;
            r_ltot      <= n_ltot;
            r_div_run   <= n_div_run;
            r_out_valid <= n_out_valid;
        end
        r_in     <= n_in;
        r_count  <= n_count;
        r_mavg   <= n_mavg;
        r_mpct   <= n_mpct;
        r_lpct   <= n_lpct;
        r_mscore <= n_mscore;
        r_lscore <= n_lscore;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign out_in_range   = (o_out_data.moisture_pct <= PCT_MAX)
                            && (o_out_data.light_pct <= PCT_MAX)
                            && (o_out_data.health_score <= PCT_MAX);
    assign count_in_range = (r_count != '0) && (r_count <= CNT_W'(WINDOW_DEPTH));
    assign idle_no_req    = (r_state == ST_IDLE) && !in_acc;

    `SAHS_ASSERT_IMP(a_out_range, i_clk, i_rst_n, o_out_valid, out_in_range)
    `SAHS_ASSERT_IMP(a_div_free_at_start, i_clk, i_rst_n, div_start, !div_stat.busy)
    `SAHS_ASSERT_NXT(a_count_sane, i_clk, i_rst_n, r_state == ST_RD, count_in_range)
    `SAHS_ASSERT_NXT(a_slot_held, i_clk, i_rst_n, idle_no_req, $stable(r_slot) && $stable(r_full))

endmodule

>>> hdl/sahs_ram.sv
// ----------------------------------------------------------------------------
// sahs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sahs_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 10
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/sahs_div.sv
// ----------------------------------------------------------------------------
// sahs_div
// Shared unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module sahs_div #(
    parameter int DIVIDEND_W = 22,
    parameter int DIVISOR_W  = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [DIVIDEND_W-1:0]  i_dividend,
    input  logic [DIVISOR_W-1:0]   i_divisor,
    output sahs_pkg::t_div_stat    o_stat,
    output logic [DIVIDEND_W-1:0]  o_quotient
);
    import sahs_pkg::*;

    localparam int STEPS = DIVIDEND_W / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [DIVISOR_W:0]    r_rem;
    logic [DIVISOR_W:0]    n_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVIDEND_W-1:0] n_quo;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [CW-1:0]         r_cnt;
    logic                  r_done;

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            n_rem = {n_rem[DIVISOR_W-1:0], n_quo[DIVIDEND_W-1]};
            n_quo = {n_quo[DIVIDEND_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_dvs}) begin
                n_rem    = n_rem - {1'b0, r_dvs};
                n_quo[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem <= '0;
                r_quo <= i_dividend;
                r_dvs <= i_divisor;
                r_cnt <= CW'(STEPS);
            end else if (r_cnt != '0) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule
